// ===== rtl/acpu_pkg.sv =====
// Shared types and constants for the accumulator processor.
// No dependencies; the ALU and top level refer to this package by scoped names.
`default_nettype none

package acpu_pkg;

    // Memory geometry
    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

    // Input word operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RAISE = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // Instruction opcodes
    localparam logic [7:0] OPC_LDW  = 8'h10;
    localparam logic [7:0] OPC_ADDW = 8'h20;
    localparam logic [7:0] OPC_CMP  = 8'h31;
    localparam logic [7:0] OPC_BLT  = 8'h33;
    localparam logic [7:0] OPC_RET  = 8'h41;
    localparam logic [7:0] OPC_CLI  = 8'h70;
    localparam logic [7:0] OPC_SEI  = 8'h71;
    localparam logic [7:0] OPC_RTI  = 8'h72;
    localparam logic [7:0] OPC_HALT = 8'hFF;

    // Interrupt vector location (big-endian word)
    localparam logic [15:0] VEC_HI_ADDR = 16'hFFFE;
    localparam logic [15:0] VEC_LO_ADDR = 16'hFFFF;

    // Reset value of the stack pointer
    localparam logic [15:0] SP_RESET = 16'hFFFE;

    // Run state as reported on the status field
    typedef enum logic [1:0] {
        RUN_ACTIVE  = 2'd0,
        RUN_HALT    = 2'd1,
        RUN_ILLEGAL = 2'd2
    } t_run;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_IRQ0,
        S_IRQ1,
        S_IRQ2,
        S_VEC0,
        S_VEC1,
        S_VEC2,
        S_FETCH,
        S_DECODE,
        S_W0,
        S_W1,
        S_BR,
        S_RET0,
        S_RET1,
        S_RTI0,
        S_RTI1,
        S_RTI2,
        S_DONE
    } t_state;

    // Request to the shared adder
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        sub;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== rtl/acpu_ram.sv =====
// Generic single-port RAM: one read per cycle plus a write on enable, registered read data.
// No dependencies.
`default_nettype none

module acpu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, always register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/acpu_alu.sv =====
// Shared 16-bit add/subtract unit used by the sequencer steps.
// Depends on acpu_pkg for the request struct.
`default_nettype none

module acpu_alu (
    input  wire acpu_pkg::t_alu_req i_req,
    output logic [15:0]             o_sum
);

    logic [15:0] w_b;

    // Invert and carry in for subtraction
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + w_b + {15'd0, i_req.sub};

endmodule

`default_nettype wire

// ===== rtl/accumulator_cpu_with_irq.sv =====
// Top level of the accumulator processor: sequencer, architectural registers,
// result register. Depends on acpu_pkg, acpu_ram and acpu_alu.
`default_nettype none

// One input word is taken at a time; o_in_stall is high until its result has
// been written to the output register. Memory loads, interrupt raises, unused
// operations and steps of a stopped core go straight to completion. A step
// fetches and decodes the opcode, then BLT reads a displacement, LDW, ADDW and
// CMP read a word, RET pops the return address and RTI pops flags and return
// address; taking an interrupt first pushes PC and flags and reads the vector.
// The single memory port's registered read gives one byte per cycle, and all
// address and data arithmetic passes through one shared 16-bit adder. A result
// held by o_out_valid with i_out_stall high does not block the next input word.
// The memory has no reset; reading a byte never written returns undefined data.
module accumulator_cpu_with_irq (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [1:0]   i_op,
    input  wire [15:0]  i_address,
    input  wire [7:0]   i_data,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_exec_pc,
    output logic [7:0]  o_opcode,
    output logic [15:0] o_acc,
    output logic        o_zero_flag,
    output logic        o_neg_flag,
    output logic        o_irq_mask,
    output logic [15:0] o_stack_ptr,
    output logic [15:0] o_next_pc,
    output logic        o_irq_taken
);

    acpu_pkg::t_state r_state, n_state;

    // Architectural state
    logic [15:0]    r_acc, n_acc;
    logic [15:0]    r_pc, n_pc;
    logic [15:0]    r_sp, n_sp;
    logic           r_z, n_z;
    logic           r_n, n_n;
    logic           r_mask, n_mask;
    logic           r_pend, n_pend;
    acpu_pkg::t_run r_run, n_run;

    // Per-word scratch
    logic [15:0] r_exec_pc, n_exec_pc;
    logic [7:0]  r_opcode, n_opcode;
    logic        r_taken, n_taken;
    logic [7:0]  r_hi, n_hi;

    // Memory and adder hookup
    logic                        w_ram_we;
    logic [acpu_pkg::MEM_AW-1:0] w_ram_addr;
    logic [7:0]                  w_ram_wdata;
    logic [7:0]                  w_rdata;
    acpu_pkg::t_alu_req          w_alu;
    logic [15:0]                 w_sum;

    logic        w_in_acc;
    logic        w_out_free;
    logic [15:0] w_word;

    assign o_in_stall = (r_state != acpu_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_word     = {r_hi, w_rdata};

    acpu_ram #(
        .WIDTH (8),
        .DEPTH (acpu_pkg::MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    acpu_alu u_alu (
        .i_req (w_alu),
        .o_sum (w_sum)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acpu_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == acpu_pkg::OP_STEP && r_run == acpu_pkg::RUN_ACTIVE) begin
                        n_state = (r_pend && !r_mask) ? acpu_pkg::S_IRQ0
                                                      : acpu_pkg::S_FETCH;
                    end else begin
                        n_state = acpu_pkg::S_DONE;
                    end
                end
            end
            acpu_pkg::S_IRQ0:  n_state = acpu_pkg::S_IRQ1;
            acpu_pkg::S_IRQ1:  n_state = acpu_pkg::S_IRQ2;
            acpu_pkg::S_IRQ2:  n_state = acpu_pkg::S_VEC0;
            acpu_pkg::S_VEC0:  n_state = acpu_pkg::S_VEC1;
            acpu_pkg::S_VEC1:  n_state = acpu_pkg::S_VEC2;
            acpu_pkg::S_VEC2:  n_state = acpu_pkg::S_FETCH;
            acpu_pkg::S_FETCH: n_state = acpu_pkg::S_DECODE;
            acpu_pkg::S_DECODE: begin
                unique case (w_rdata) inside
                    acpu_pkg::OPC_LDW, acpu_pkg::OPC_ADDW, acpu_pkg::OPC_CMP:
                        n_state = acpu_pkg::S_W0;
                    acpu_pkg::OPC_BLT: n_state = acpu_pkg::S_BR;
                    acpu_pkg::OPC_RET: n_state = acpu_pkg::S_RET0;
                    acpu_pkg::OPC_RTI: n_state = acpu_pkg::S_RTI0;
                    default:           n_state = acpu_pkg::S_DONE;
                endcase
            end
            acpu_pkg::S_W0:   n_state = acpu_pkg::S_W1;
            acpu_pkg::S_W1:   n_state = acpu_pkg::S_DONE;
            acpu_pkg::S_BR:   n_state = acpu_pkg::S_DONE;
            acpu_pkg::S_RET0: n_state = acpu_pkg::S_RET1;
            acpu_pkg::S_RET1: n_state = acpu_pkg::S_DONE;
            acpu_pkg::S_RTI0: n_state = acpu_pkg::S_RTI1;
            acpu_pkg::S_RTI1: n_state = acpu_pkg::S_RTI2;
            acpu_pkg::S_RTI2: n_state = acpu_pkg::S_DONE;
            acpu_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = acpu_pkg::S_IDLE;
                end
            end
            default: n_state = acpu_pkg::S_IDLE;
        endcase
    end

    // Step outputs: memory access, adder operands, register updates
    always_comb begin
        n_acc     = r_acc;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_z       = r_z;
        n_n       = r_n;
        n_mask    = r_mask;
        n_pend    = r_pend;
        n_run     = r_run;
        n_exec_pc = r_exec_pc;
        n_opcode  = r_opcode;
        n_taken   = r_taken;
        n_hi      = r_hi;

        w_ram_we    = 1'b0;
        w_ram_addr  = r_pc;
        w_ram_wdata = i_data;
        w_alu       = '{a: r_pc, b: 16'd1, sub: 1'b0};

        unique case (r_state)
            acpu_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_exec_pc = 16'd0;
                    n_opcode  = 8'd0;
                    n_taken   = 1'b0;
                    if (i_op == acpu_pkg::OP_LOAD) begin
                        w_ram_we   = 1'b1;
                        w_ram_addr = i_address;
                    end else if (i_op == acpu_pkg::OP_RAISE) begin
                        n_pend = 1'b1;
                    end
                end
            end
            // Push PC high, PC low, then flags
            acpu_pkg::S_IRQ0: begin
                w_alu       = '{a: r_sp, b: 16'd2, sub: 1'b1};
                w_ram_we    = 1'b1;
                w_ram_addr  = w_sum;
                w_ram_wdata = r_pc[15:8];
                n_sp        = w_sum;
            end
            acpu_pkg::S_IRQ1: begin
                w_alu       = '{a: r_sp, b: 16'd1, sub: 1'b0};
                w_ram_we    = 1'b1;
                w_ram_addr  = w_sum;
                w_ram_wdata = r_pc[7:0];
            end
            acpu_pkg::S_IRQ2: begin
                w_alu       = '{a: r_sp, b: 16'd1, sub: 1'b1};
                w_ram_we    = 1'b1;
                w_ram_addr  = w_sum;
                w_ram_wdata = {5'd0, r_mask, r_z, r_n};
                n_sp        = w_sum;
                n_mask      = 1'b1;
                n_pend      = 1'b0;
            end
            // Load PC from the vector
            acpu_pkg::S_VEC0: begin
                w_ram_addr = acpu_pkg::VEC_HI_ADDR;
            end
            acpu_pkg::S_VEC1: begin
                w_ram_addr = acpu_pkg::VEC_LO_ADDR;
                n_hi       = w_rdata;
            end
            acpu_pkg::S_VEC2: begin
                n_pc    = w_word;
                n_taken = 1'b1;
            end
            // Fetch opcode and advance PC
            acpu_pkg::S_FETCH: begin
                w_ram_addr = r_pc;
                n_exec_pc  = r_pc;
                n_pc       = w_sum;
            end
            acpu_pkg::S_DECODE: begin
                n_opcode = w_rdata;
                unique case (w_rdata) inside
                    acpu_pkg::OPC_LDW, acpu_pkg::OPC_ADDW, acpu_pkg::OPC_CMP,
                    acpu_pkg::OPC_BLT: begin
                        w_ram_addr = r_pc;
                        n_pc       = w_sum;
                    end
                    acpu_pkg::OPC_RET, acpu_pkg::OPC_RTI: begin
                        w_ram_addr = r_sp;
                    end
                    acpu_pkg::OPC_CLI:  n_mask = 1'b0;
                    acpu_pkg::OPC_SEI:  n_mask = 1'b1;
                    acpu_pkg::OPC_HALT: n_run  = acpu_pkg::RUN_HALT;
                    default:            n_run  = acpu_pkg::RUN_ILLEGAL;
                endcase
            end
            // Immediate word: fetch low byte, hold high byte
            acpu_pkg::S_W0: begin
                w_ram_addr = r_pc;
                n_pc       = w_sum;
                n_hi       = w_rdata;
            end
            acpu_pkg::S_W1: begin
                w_alu = '{a: r_acc, b: w_word, sub: (r_opcode != acpu_pkg::OPC_ADDW)};
                case (r_opcode)
                    acpu_pkg::OPC_LDW: begin
                        n_acc = w_word;
                        n_z   = (w_word == 16'd0);
                        n_n   = w_word[15];
                    end
                    acpu_pkg::OPC_ADDW: begin
                        n_acc = w_sum;
                        n_z   = (w_sum == 16'd0);
                        n_n   = w_sum[15];
                    end
                    default: begin
                        n_z = (w_sum == 16'd0);
                        n_n = w_sum[15];
                    end
                endcase
            end
            // Branch on negative with sign-extended displacement
            acpu_pkg::S_BR: begin
                w_alu = '{a: r_pc, b: {{8{w_rdata[7]}}, w_rdata}, sub: 1'b0};
                if (r_n) begin
                    n_pc = w_sum;
                end
            end
            // Pop return address
            acpu_pkg::S_RET0, acpu_pkg::S_RTI1: begin
                w_alu      = '{a: r_sp, b: 16'd1, sub: 1'b0};
                w_ram_addr = w_sum;
                n_hi       = w_rdata;
            end
            acpu_pkg::S_RET1, acpu_pkg::S_RTI2: begin
                w_alu = '{a: r_sp, b: 16'd2, sub: 1'b0};
                n_pc  = w_word;
                n_sp  = w_sum;
            end
            // Pop flags, then start the return address
            acpu_pkg::S_RTI0: begin
                w_alu      = '{a: r_sp, b: 16'd1, sub: 1'b0};
                w_ram_addr = w_sum;
                n_sp       = w_sum;
                n_n        = w_rdata[0];
                n_z        = w_rdata[1];
                n_mask     = w_rdata[2];
            end
            acpu_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acpu_pkg::S_IDLE;
            r_acc   <= 16'd0;
            r_pc    <= 16'd0;
            r_sp    <= acpu_pkg::SP_RESET;
            r_z     <= 1'b0;
            r_n     <= 1'b0;
            r_mask  <= 1'b1;
            r_pend  <= 1'b0;
            r_run   <= acpu_pkg::RUN_ACTIVE;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_z     <= n_z;
            r_n     <= n_n;
            r_mask  <= n_mask;
            r_pend  <= n_pend;
            r_run   <= n_run;
        end
    end

    // Per-word scratch registers
    always_ff @(posedge i_clk) begin
        r_exec_pc <= n_exec_pc;
        r_opcode  <= n_opcode;
        r_taken   <= n_taken;
        r_hi      <= n_hi;
    end

    // Result word valid: set on completion, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == acpu_pkg::S_DONE && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    // Result word payload: snapshot the state on completion
    always_ff @(posedge i_clk) begin
        if (r_state == acpu_pkg::S_DONE && w_out_free) begin
            o_status    <= r_run;
            o_exec_pc   <= r_exec_pc;
            o_opcode    <= r_opcode;
            o_acc       <= r_acc;
            o_zero_flag <= r_z;
            o_neg_flag  <= r_n;
            o_irq_mask  <= r_mask;
            o_stack_ptr <= r_sp;
            o_next_pc   <= r_pc;
            o_irq_taken <= r_taken;
        end
    end

    // A stopped core stays stopped
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run != acpu_pkg::RUN_ACTIVE) |=> (r_run == $past(r_run)))
        else $error("run state left a stop");

    // Interrupt entry masks and clears the line
    a_irq_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acpu_pkg::S_IRQ2) |=> (r_mask && !r_pend))
        else $error("interrupt entry did not mask or clear pending");

    // A new result only comes from the completion step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == acpu_pkg::S_DONE))
        else $error("result valid rose outside completion");

    // Busy sequencer only returns to idle through the completion step
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != acpu_pkg::S_IDLE && r_state != acpu_pkg::S_DONE)
            |=> (r_state != acpu_pkg::S_IDLE))
        else $error("sequencer returned to idle without completing");

endmodule

`default_nettype wire

// ===== dv/tb_accumulator_cpu_with_irq.sv =====
// Testbench for accumulator_cpu_with_irq: a directed program, random programs, an
// output hold-off and the sticky stop, each checked against an in-bench CPU model.
// Depends on acpu_pkg and the RTL of accumulator_cpu_with_irq.
module tb_accumulator_cpu_with_irq;
    import acpu_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 720;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] exec_pc;
        logic [7:0]  opcode;
        logic [15:0] acc;
        logic        zero;
        logic        neg;
        logic        mask;
        logic [15:0] sp;
        logic [15:0] next_pc;
        logic        taken;
    } t_cpu_result;

    // DUT ports
    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_LOAD;
    logic [15:0] i_address = '0;
    logic [7:0]  i_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_exec_pc;
    logic [7:0]  o_opcode;
    logic [15:0] o_acc;
    logic        o_zero_flag;
    logic        o_neg_flag;
    logic        o_irq_mask;
    logic [15:0] o_stack_ptr;
    logic [15:0] o_next_pc;
    logic        o_irq_taken;

    // CPU model state
    logic [7:0]  mem_img [0:65535];
    bit          written [0:65535];
    logic [15:0] acc_m, pc_m, sp_m;
    logic        z_m, n_m, mask_m, pend_m;
    t_run        run_m;

    // results of the last model step, and what a dry step found missing
    logic [15:0] fetch_pc;
    logic [7:0]  fetch_opc;
    logic        step_taken;
    bit          gap_found, gap_code, opc_pushed, hit_push;
    logic [15:0] gap_addr;
    logic [15:0] push_addr [0:2];
    logic [7:0]  push_data [0:2];
    int          push_n;

    t_cpu_result expected_results [$];
    t_cpu_result want_r;
    logic [7:0]  plan_bytes [$];
    int          errors = 0;
    int          items_sent = 0;
    int          cycle_count;
    int          hold_ask = 0;
    logic        rx_hold = 1'b0;
    bit          idle_on = 1'b1;

    accumulator_cpu_with_irq dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [1:0] flags_of(logic [15:0] v);
        return {v == 16'd0, v[15]};
    endfunction

    function automatic bit runnable(logic [7:0] b);
        case (b)
            OPC_LDW, OPC_ADDW, OPC_CMP, OPC_BLT, OPC_RET, OPC_CLI, OPC_SEI, OPC_RTI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_byte(logic [15:0] a, logic [7:0] v);
        push_addr[push_n[1:0]] = a;
        push_data[push_n[1:0]] = v;
        push_n++;
    endfunction

    // Read through the bytes pushed in this step; note the first unwritten byte
    function automatic logic [7:0] read_byte(logic [15:0] a, bit code);
        logic [7:0] v;
        int k;
        v = mem_img[a];
        hit_push = 1'b0;
        for (k = 0; k < push_n; k++) begin
            if (push_addr[k[1:0]] == a) begin
                v = push_data[k[1:0]];
                hit_push = 1'b1;
            end
        end
        if (!hit_push && !written[a] && !gap_found) begin
            gap_found = 1'b1;
            gap_addr = a;
            gap_code = code;
        end
        return v;
    endfunction

    function automatic logic [15:0] read_word(logic [15:0] a);
        logic [7:0] hi, lo;
        hi = read_byte(a, 1'b0);
        lo = read_byte(a + 16'd1, 1'b0);
        return {hi, lo};
    endfunction

    // Execute one step on the model; commit only when asked
    function automatic void exec_instruction(bit commit);
        logic [15:0] acc, pc, sp, xpc;
        logic [7:0]  opc, d, f;
        logic        z, n, msk, pend, taken;
        t_run        run;
        int          k;
        acc = acc_m;
        pc = pc_m;
        sp = sp_m;
        z = z_m;
        n = n_m;
        msk = mask_m;
        pend = pend_m;
        run = run_m;
        xpc = '0;
        opc = '0;
        taken = 1'b0;
        gap_found = 1'b0;
        opc_pushed = 1'b0;
        push_n = 0;
        if (run == RUN_ACTIVE) begin
            // enter the handler: push PC big-endian, then N, Z, I
            if (pend && !msk) begin
                sp = sp - 16'd2;
                push_byte(sp, pc[15:8]);
                push_byte(sp + 16'd1, pc[7:0]);
                sp = sp - 16'd1;
                push_byte(sp, {5'd0, msk, z, n});
                msk = 1'b1;
                pend = 1'b0;
                taken = 1'b1;
                pc = read_word(VEC_HI_ADDR);
            end
            xpc = pc;
            opc = read_byte(pc, 1'b1);
            opc_pushed = hit_push;
            pc = pc + 16'd1;
            case (opc)
                OPC_LDW: begin
                    acc = read_word(pc);
                    pc = pc + 16'd2;
                    {z, n} = flags_of(acc);
                end
                OPC_ADDW: begin
                    acc = acc + read_word(pc);
                    pc = pc + 16'd2;
                    {z, n} = flags_of(acc);
                end
                OPC_CMP: begin
                    {z, n} = flags_of(acc - read_word(pc));
                    pc = pc + 16'd2;
                end
                OPC_BLT: begin
                    d = read_byte(pc, 1'b0);
                    pc = pc + 16'd1;
                    if (n) begin
                        pc = pc + {{8{d[7]}}, d};
                    end
                end
                OPC_RET: begin
                    pc = read_word(sp);
                    sp = sp + 16'd2;
                end
                OPC_CLI: msk = 1'b0;
                OPC_SEI: msk = 1'b1;
                OPC_RTI: begin
                    f = read_byte(sp, 1'b0);
                    sp = sp + 16'd1;
                    n = f[0];
                    z = f[1];
                    msk = f[2];
                    pc = read_word(sp);
                    sp = sp + 16'd2;
                end
                OPC_HALT: run = RUN_HALT;
                default: run = RUN_ILLEGAL;
            endcase
        end
        fetch_pc = xpc;
        fetch_opc = opc;
        if (commit) begin
            for (k = 0; k < push_n; k++) begin
                mem_img[push_addr[k[1:0]]] = push_data[k[1:0]];
                written[push_addr[k[1:0]]] = 1'b1;
            end
            acc_m = acc;
            pc_m = pc;
            sp_m = sp;
            z_m = z;
            n_m = n;
            mask_m = msk;
            pend_m = pend;
            run_m = run;
            step_taken = taken;
        end
    endfunction

    // Apply one input word to the model and queue its result
    function automatic void predict_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        t_cpu_result r;
        fetch_pc = '0;
        fetch_opc = '0;
        step_taken = 1'b0;
        case (op)
            OP_LOAD: begin
                mem_img[addr] = data;
                written[addr] = 1'b1;
            end
            OP_RAISE: pend_m = 1'b1;
            OP_STEP: exec_instruction(1'b1);
            default: ;
        endcase
        r.status = run_m;
        r.exec_pc = fetch_pc;
        r.opcode = fetch_opc;
        r.acc = acc_m;
        r.zero = z_m;
        r.neg = n_m;
        r.mask = mask_m;
        r.sp = sp_m;
        r.next_pc = pc_m;
        r.taken = step_taken;
        expected_results.push_back(r);
    endfunction

    function automatic logic [7:0] pick_opcode();
        int w;
        w = $urandom_range(99);
        if (w < 16) return OPC_LDW;
        if (w < 32) return OPC_ADDW;
        if (w < 48) return OPC_CMP;
        if (w < 64) return OPC_BLT;
        if (w < 73) return OPC_RET;
        if (w < 85) return OPC_CLI;
        if (w < 91) return OPC_SEI;
        return OPC_RTI;
    endfunction

    function automatic logic [7:0] fill_value(bit code, bit forced, logic [7:0] want_opc);
        if (plan_bytes.size() > 0) return plan_bytes.pop_front();
        if (!code) return 8'($urandom_range(255));
        return forced ? want_opc : pick_opcode();
    endfunction

    // Offer one word; hold valid high across back-to-back words
    task automatic send_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        while (idle_on && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_word(op, addr, data);
        if (op != OP_UNUSED) items_sent++;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_address <= addr;
        i_data <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Load every byte the next step reads, patch a stopping opcode, then step
    task automatic step_cpu(bit forced, logic [7:0] want_opc);
        bit ready;
        int tries;
        ready = 1'b0;
        tries = 0;
        while (!ready) begin
            exec_instruction(1'b0);
            if (gap_found) begin
                send_word(OP_LOAD, gap_addr, fill_value(gap_code, forced, want_opc));
            end else if (run_m == RUN_ACTIVE && tries < 4 &&
                         (forced ? fetch_opc != want_opc : !runnable(fetch_opc))) begin
                tries++;
                if (opc_pushed) begin
                    send_word(OP_LOAD, VEC_HI_ADDR, 8'($urandom_range(255)));
                end else begin
                    send_word(OP_LOAD, fetch_pc, forced ? want_opc : pick_opcode());
                end
            end else begin
                ready = 1'b1;
            end
        end
        send_word(OP_STEP, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    endtask

    function automatic void cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: mismatch on %s: expected %h actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    // Check each accepted result, then draw the next output stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected: status %h exec_pc %h",
                         $time, o_status, o_exec_pc);
                errors++;
            end else begin
                want_r = expected_results.pop_front();
                cmp_field("status", 16'(want_r.status), 16'(o_status));
                cmp_field("exec_pc", want_r.exec_pc, o_exec_pc);
                cmp_field("opcode", 16'(want_r.opcode), 16'(o_opcode));
                cmp_field("acc", want_r.acc, o_acc);
                cmp_field("zero_flag", 16'(want_r.zero), 16'(o_zero_flag));
                cmp_field("neg_flag", 16'(want_r.neg), 16'(o_neg_flag));
                cmp_field("irq_mask", 16'(want_r.mask), 16'(o_irq_mask));
                cmp_field("stack_ptr", want_r.sp, o_stack_ptr);
                cmp_field("next_pc", want_r.next_pc, o_next_pc);
                cmp_field("irq_taken", 16'(want_r.taken), 16'(o_irq_taken));
            end
        end
        i_out_stall <= rx_hold || (idle_on && $urandom_range(99) < 31);
    end

    // Hold the output off for a long stretch when asked
    initial begin
        int seen;
        seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ask != seen) begin
                seen = hold_ask;
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Hand-built program: branch into the word at 0xFFFE, sum to zero, take and
    // return from an interrupt raised while masked, then pop the stack past 0xFFFF
    task automatic test_directed_program();
        send_word(OP_UNUSED, 16'hFFFF, 8'hFF);
        send_word(OP_RAISE, 16'h0000, 8'h00);
        plan_bytes = '{OPC_CMP, 8'h33, 8'h70};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_BLT, 8'hF9};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_LDW, 8'h80};
        step_cpu(1'b0, 8'h00);
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_ADDW, 8'h7F, 8'hCF};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_CLI};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_RTI};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_SEI};
        step_cpu(1'b0, 8'h00);
        plan_bytes = '{OPC_RET};
        step_cpu(1'b0, 8'h00);
        plan_bytes.delete();
    endtask

    // Random programs with interrupt round trips, compare-and-branch pairs and noise
    task automatic test_random_program();
        int pick;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = !(items_sent >= 300 && items_sent < 420);
            pick = $urandom_range(99);
            if (pick < 58) begin
                step_cpu(1'b0, 8'h00);
            end else if (pick < 68) begin
                send_word(OP_RAISE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            end else if (pick < 72) begin
                send_word(OP_UNUSED, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            end else if (pick < 82) begin
                send_word(OP_LOAD, 16'($urandom_range(65535)), 8'($urandom_range(255)));
            end else if (pick < 91) begin
                step_cpu(1'b1, OPC_CLI);
                send_word(OP_RAISE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
                step_cpu(1'b1, OPC_RTI);
            end else begin
                step_cpu(1'b1, OPC_CMP);
                step_cpu(1'b1, OPC_BLT);
            end
        end
        idle_on = 1'b1;
    endtask

    // Keep offering steps while the output is held off
    task automatic test_output_holdoff();
        int k;
        hold_ask++;
        for (k = 0; k < 12; k++) begin
            step_cpu(1'b0, 8'h00);
        end
    endtask

    // Stop the core with HALT or an illegal opcode, then poke it while stopped
    task automatic test_stop_states();
        logic [7:0] stop_opc;
        stop_opc = OPC_HALT;
        if ($urandom_range(1) == 1) begin
            do begin
                stop_opc = 8'($urandom_range(255));
            end while (runnable(stop_opc) || stop_opc == OPC_HALT);
        end
        step_cpu(1'b1, stop_opc);
        step_cpu(1'b0, 8'h00);
        send_word(OP_RAISE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        step_cpu(1'b0, 8'h00);
        send_word(OP_LOAD, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        send_word(OP_UNUSED, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        step_cpu(1'b0, 8'h00);
    endtask

    initial begin
        int a;
        for (a = 0; a < 65536; a++) begin
            mem_img[a[15:0]] = 8'h00;
            written[a[15:0]] = 1'b0;
        end
        acc_m = '0;
        pc_m = '0;
        sp_m = SP_RESET;
        z_m = 1'b0;
        n_m = 1'b0;
        mask_m = 1'b1;
        pend_m = 1'b0;
        run_m = RUN_ACTIVE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_program();
        test_random_program();
        test_output_holdoff();
        test_stop_states();
        i_in_valid <= 1'b0;
        // drain, then give the last result time to settle
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
